// ===== rtl/selection_sort_key_payload_64_core_macros.svh =====
`ifndef SELECTION_SORT_KEY_PAYLOAD_64_CORE_MACROS_SVH
`define SELECTION_SORT_KEY_PAYLOAD_64_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SSK_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssk check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SSK_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssk check failed");

`endif

// ===== rtl/ssk_pkg.sv =====
package ssk_pkg;

   localparam int DEFAULT_MAX_ELEMENTS = 64;
   localparam int KEY_W                = 64;
   localparam int PAYLOAD_W            = 64;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KEY_W-1:0]     elem_key;
      logic [PAYLOAD_W-1:0] elem_payload;
      logic                 elem_last;
   } ssk_req_type;

   typedef struct packed {
      logic [KEY_W-1:0]     sorted_key;
      logic [PAYLOAD_W-1:0] sorted_payload;
      logic                 out_last;
      logic                 batch_overflow;
   } ssk_rsp_type;

   // One classified element on its way from front to back.
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic                 last;
      logic                 drop;
   } ssk_entry_type;

   typedef struct packed {
      logic loading;
      logic fill_zero;
      logic fill_full;
   } ssk_status_type;

endpackage

// ===== rtl/ssk_front.sv =====
module ssk_front #(
   parameter int MAX_ELEMENTS = ssk_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssk_pkg::ssk_req_type  req_item,
   input  logic                  q_full,
   output logic                  q_push,
   output ssk_pkg::ssk_entry_type q_push_entry
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             drop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign drop      = (count_ff == CNT_W'(MAX_ELEMENTS));

   assign q_push               = accept;
   assign q_push_entry.key     = req_item.elem_key;
   assign q_push_entry.payload = req_item.elem_payload;
   assign q_push_entry.last    = req_item.elem_last;
   assign q_push_entry.drop    = drop;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_item.elem_last) begin
            count_in = '0;
         end else if (!drop) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/ssk_queue.sv =====
module ssk_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ssk_pkg::ssk_entry_type push_entry,
   output logic                   full,
   output logic                   valid,
   output ssk_pkg::ssk_entry_type head,
   input  logic                   pop
);

   localparam int PTR_W = ssk_pkg::QUEUE_PTR_W;
   localparam int CNT_W = ssk_pkg::QUEUE_CNT_W;

   ssk_pkg::ssk_entry_type entry_ff [ssk_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full  = (count_ff == CNT_W'(ssk_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ssk_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ssk_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ssk_back.sv =====
module ssk_back #(
   parameter int MAX_ELEMENTS = ssk_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ssk_pkg::ssk_entry_type q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ssk_pkg::ssk_rsp_type   rsp_item,
   output ssk_pkg::ssk_status_type status
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int KW    = ssk_pkg::KEY_W;
   localparam int PW    = ssk_pkg::PAYLOAD_W;

   typedef enum logic [7:0] {
      S_LOAD    = 8'b0000_0001,
      S_POS     = 8'b0000_0010,
      S_POS_CAP = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_SWAP_A  = 8'b0001_0000,
      S_SWAP_B  = 8'b0010_0000,
      S_OUT_RD  = 8'b0100_0000,
      S_OUT_LD  = 8'b1000_0000
   } state_type;

   logic [KW-1:0] key_mem [MAX_ELEMENTS];
   logic [PW-1:0] pay_mem [MAX_ELEMENTS];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [KW-1:0]    pos_key_ff, pos_key_in;
   logic [PW-1:0]    pos_pay_ff, pos_pay_in;
   logic [KW-1:0]    best_key_ff, best_key_in;
   logic [PW-1:0]    best_pay_ff, best_pay_in;
   logic [KW-1:0]    rd_key_ff;
   logic [PW-1:0]    rd_pay_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ssk_pkg::ssk_rsp_type rsp_item_ff, rsp_item_in;

   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KW-1:0]    wr_key;
   logic [PW-1:0]    wr_pay;
   logic [CNT_W-1:0] fill_m1;
   logic [IDX_W-1:0] last_idx;
   logic             out_free;

   assign fill_m1  = fill_ff - CNT_W'(1);
   assign last_idx = fill_m1[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item         = rsp_item_ff;
   assign status.loading   = (state_ff == S_LOAD);
   assign status.fill_zero = (fill_ff == '0);
   assign status.fill_full = (fill_ff == CNT_W'(MAX_ELEMENTS));

   // Read address: the scan state fetches one ahead of the entry it compares.
   always_comb begin
      unique case (state_ff)
         S_POS:              rd_addr = pos_ff;
         S_POS_CAP:          rd_addr = scan_ff;
         S_SCAN:             rd_addr = scan_ff + IDX_W'(1);
         S_OUT_RD, S_OUT_LD: rd_addr = k_ff;
         default:            rd_addr = pos_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_key  = best_key_ff;
      wr_pay  = best_pay_ff;
      unique case (state_ff)
         S_LOAD: begin
            wr_en   = q_valid && !q_entry.drop;
            wr_addr = fill_ff[IDX_W-1:0];
            wr_key  = q_entry.key;
            wr_pay  = q_entry.payload;
         end
         S_SWAP_A: begin
            wr_en = 1'b1;
         end
         S_SWAP_B: begin
            // best == pos puts the original pair back in place
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_key  = pos_key_ff;
            wr_pay  = pos_pay_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_pay_ff <= pay_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      k_in         = k_ff;
      pos_key_in   = pos_key_ff;
      pos_pay_in   = pos_pay_ff;
      best_key_in  = best_key_ff;
      best_pay_in  = best_pay_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (q_entry.last) begin
                  pos_in = '0;
                  k_in   = '0;
                  state_in = (fill_in >= CNT_W'(2)) ? S_POS : S_OUT_RD;
               end
            end
         end
         S_POS: begin
            scan_in  = pos_ff + IDX_W'(1);
            state_in = S_POS_CAP;
         end
         S_POS_CAP: begin
            pos_key_in  = rd_key_ff;
            pos_pay_in  = rd_pay_ff;
            best_key_in = rd_key_ff;
            best_pay_in = rd_pay_ff;
            best_idx_in = pos_ff;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            // strict compare keeps the first smallest key
            if (rd_key_ff < best_key_ff) begin
               best_key_in = rd_key_ff;
               best_pay_in = rd_pay_ff;
               best_idx_in = scan_ff;
            end
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == last_idx) begin
               state_in = S_SWAP_A;
            end
         end
         S_SWAP_A: begin
            state_in = S_SWAP_B;
         end
         S_SWAP_B: begin
            pos_in = pos_ff + IDX_W'(1);
            if ((CNT_W'(pos_ff) + CNT_W'(2)) < fill_ff) begin
               state_in = S_POS;
            end else begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.sorted_key     = rd_key_ff;
               rsp_item_in.sorted_payload = rd_pay_ff;
               rsp_item_in.out_last       = (k_ff == last_idx);
               rsp_item_in.batch_overflow = ovf_ff;
               if (k_ff == last_idx) begin
                  fill_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         scan_ff      <= '0;
         best_idx_ff  <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         scan_ff      <= scan_in;
         best_idx_ff  <= best_idx_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_key_ff  <= pos_key_in;
      pos_pay_ff  <= pos_pay_in;
      best_key_ff <= best_key_in;
      best_pay_ff <= best_pay_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// ===== rtl/selection_sort_key_payload_64_core.sv =====
// Batch sorter for 64-bit key / 64-bit payload pairs, ascending by unsigned key.
// Input channel req_*: one pair per accepted item; elem_last closes the batch.
// Result channel rsp_*: one item per stored pair in sorted order, out_last on
// the final one, batch_overflow on all of them if elements were dropped.
// Up to MAX_ELEMENTS pairs are kept; later ones in the batch are dropped.
// Loading takes one item per cycle from behind a two-entry queue, so once the
// queue is below full req_stall stays low while loading. Selection sort runs on
// one comparator against key and payload memories with one registered read port:
// each position is fetched (S_POS, S_POS_CAP), the entries after it are scanned
// for the smallest key (S_SCAN), and that pair is swapped into place (S_SWAP_A,
// S_SWAP_B). Each result is read from memory (S_OUT_RD), then loaded into the
// output register (S_OUT_LD) when the output is free.
// While sorting or emitting, new items fill the queue and then see req_stall.
// A stalled result holds in the output register and the back end waits.
// Reset (synchronous, active high) empties the queue, clears the fill count
// and overflow flag and drops any result not yet taken.
`include "selection_sort_key_payload_64_core_macros.svh"

module selection_sort_key_payload_64_core #(
   parameter int MAX_ELEMENTS = ssk_pkg::DEFAULT_MAX_ELEMENTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ssk_pkg::ssk_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssk_pkg::ssk_rsp_type rsp_item
);

   logic                    q_full;
   logic                    q_push;
   ssk_pkg::ssk_entry_type  q_push_entry;
   logic                    q_valid;
   ssk_pkg::ssk_entry_type  q_head;
   logic                    q_pop;
   ssk_pkg::ssk_status_type back_status;

   ssk_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_push_entry (q_push_entry)
   );

   ssk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   ssk_back #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .status    (back_status)
   );

   // front classification must agree with the back end's fill count
   `SSK_ASSERT_IMPLY(a_drop_only_when_full, q_pop && q_head.drop, back_status.fill_full)
   `SSK_ASSERT_IMPLY(a_store_only_below_full, q_pop && !q_head.drop, !back_status.fill_full)
   `SSK_ASSERT_IMPLY(a_pop_only_loading, q_pop, q_valid && back_status.loading)
   `SSK_ASSERT_NEXT(a_close_starts_work, q_pop && q_head.last, !back_status.loading)
   `SSK_ASSERT_IMPLY(a_busy_has_items, !back_status.loading, !back_status.fill_zero)

endmodule
